>>> hdl/b2d_pkg.sv
`timescale 1ns / 1ps

package b2d_pkg;

    // Widths of the input words and the result fields.
    localparam int WORD_W         = 64;
    localparam int DIGIT_GROUP_W  = 64;
    localparam int GROUP_COUNT_W  = 5;

    // Default configuration of the converter.
    localparam int VALUE_BITS_DEF   = 256;
    localparam int GROUP_DIGITS_DEF = 16;

    // Width of one BCD digit.
    localparam int BCD_W = 4;

endpackage

>>> hdl/b2d_if.sv
`timescale 1ns / 1ps

// Input channel: one beat carries the 256-bit value as four words.
interface b2d_in_if;
    logic                      valid;
    logic                      ready;
    logic [b2d_pkg::WORD_W-1:0] value_lo;
    logic [b2d_pkg::WORD_W-1:0] value_mid;
    logic [b2d_pkg::WORD_W-1:0] value_hi_low;
    logic [b2d_pkg::WORD_W-1:0] value_hi_high;

    modport source (output valid, output value_lo, output value_mid,
                    output value_hi_low, output value_hi_high, input ready);
    modport sink   (input valid, input value_lo, input value_mid,
                    input value_hi_low, input value_hi_high, output ready);
endinterface

// Output channel: one beat carries one packed BCD digit group.
interface b2d_out_if;
    logic                             valid;
    logic                             ready;
    logic [b2d_pkg::DIGIT_GROUP_W-1:0] digit_group;
    logic [b2d_pkg::GROUP_COUNT_W-1:0] group_digits;
    logic                             last_group;

    modport source (output valid, output digit_group, output group_digits,
                    output last_group, input ready);
    modport sink   (input valid, input digit_group, input group_digits,
                    input last_group, output ready);
endinterface

>>> hdl/binary256_to_decimal_unit.sv
`timescale 1ns / 1ps

// Unsigned binary to decimal converter. A beat on in_ch carries a value of
// VALUE_BITS bits (higher bits are ignored); the unit answers with one to
// ceil(MAX_DIGITS / GROUP_DIGITS) beats on out_ch, most significant group
// first, each holding up to GROUP_DIGITS packed BCD digits with leading zeros
// suppressed, the first group right-aligned and the final one flagged by
// last_group. A zero value gives the single digit 0. Conversion runs
// shift-and-add-3 over a BCD register, one input bit per cycle; an item is
// loaded, converted, then unloaded one group slot of the BCD register at a
// time, leading all-zero groups being dropped, and handing a group to the
// output register waits while that register stays full; the next item is
// taken once the last group has been handed to the output register.
module binary256_to_decimal_unit #(
    parameter int VALUE_BITS   = b2d_pkg::VALUE_BITS_DEF,
    parameter int GROUP_DIGITS = b2d_pkg::GROUP_DIGITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    b2d_in_if.sink      in_ch,
    b2d_out_if.source   out_ch
);

    // Sizes derived from the parameters.
    localparam int MAX_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int NUM_GROUPS = (MAX_DIGITS + GROUP_DIGITS - 1) / GROUP_DIGITS;
    localparam int BCD_DIGITS = NUM_GROUPS * GROUP_DIGITS;
    localparam int BCD_BITS   = BCD_DIGITS * b2d_pkg::BCD_W;
    localparam int GROUP_BITS = GROUP_DIGITS * b2d_pkg::BCD_W;
    localparam int BIT_CNT_W  = $clog2(VALUE_BITS + 1);
    localparam int GRP_CNT_W  = $clog2(NUM_GROUPS + 1);
    localparam int FULL_W     = 4 * b2d_pkg::WORD_W;

    // State codes.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]                         state_reg, state_next;
    logic [VALUE_BITS-1:0]              bin_reg, bin_next;
    logic [BCD_BITS-1:0]                bcd_reg, bcd_next;
    logic [BIT_CNT_W-1:0]               bit_cnt_reg, bit_cnt_next;
    logic [GRP_CNT_W-1:0]               grp_cnt_reg, grp_cnt_next;
    logic                               started_reg, started_next;
    logic                               out_valid_reg, out_valid_next;
    logic [b2d_pkg::DIGIT_GROUP_W-1:0]  out_group_reg, out_group_next;
    logic [b2d_pkg::GROUP_COUNT_W-1:0]  out_count_reg, out_count_next;
    logic                               out_last_reg, out_last_next;

    logic [FULL_W-1:0]                  in_full;
    logic [BCD_BITS-1:0]                bcd_adj;
    logic [GROUP_BITS-1:0]              top_group;
    logic [b2d_pkg::GROUP_COUNT_W-1:0]  lead_count;
    logic                               top_zero;
    logic                               last_slot;
    logic                               out_free;

    assign in_full = {in_ch.value_hi_high, in_ch.value_hi_low,
                      in_ch.value_mid, in_ch.value_lo};

    // Add-3 correction of every BCD digit that is five or more.
    always_comb
    begin
        for (int d = 0; d < BCD_DIGITS; d++)
        begin
            if (bcd_reg[d*b2d_pkg::BCD_W +: b2d_pkg::BCD_W] >= 4'd5)
            begin
                bcd_adj[d*b2d_pkg::BCD_W +: b2d_pkg::BCD_W] =
                    bcd_reg[d*b2d_pkg::BCD_W +: b2d_pkg::BCD_W] + 4'd3;
            end
            else
            begin
                bcd_adj[d*b2d_pkg::BCD_W +: b2d_pkg::BCD_W] =
                    bcd_reg[d*b2d_pkg::BCD_W +: b2d_pkg::BCD_W];
            end
        end
    end

    // Top group of the BCD register and the count of its significant digits.
    assign top_group = bcd_reg[BCD_BITS-1 -: GROUP_BITS];
    assign top_zero  = (top_group == '0);
    assign last_slot = (grp_cnt_reg == GRP_CNT_W'(NUM_GROUPS - 1));
    assign out_free  = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        lead_count = b2d_pkg::GROUP_COUNT_W'(1);
        for (int k = 0; k < GROUP_DIGITS; k++)
        begin
            if (top_group[k*b2d_pkg::BCD_W +: b2d_pkg::BCD_W] != '0)
            begin
                lead_count = b2d_pkg::GROUP_COUNT_W'(k + 1);
            end
        end
    end

    // Sequencer: load, convert one bit per cycle, then unload group by group.
    always_comb
    begin
        state_next     = state_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        bit_cnt_next   = bit_cnt_reg;
        grp_cnt_next   = grp_cnt_reg;
        started_next   = started_reg;
        out_valid_next = out_valid_reg;
        out_group_next = out_group_reg;
        out_count_next = out_count_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    bin_next     = in_full[VALUE_BITS-1:0];
                    bcd_next     = '0;
                    bit_cnt_next = '0;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next     = {bcd_adj[BCD_BITS-2:0], bin_reg[VALUE_BITS-1]};
                bin_next     = {bin_reg[VALUE_BITS-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
                if (bit_cnt_reg == BIT_CNT_W'(VALUE_BITS - 1))
                begin
                    grp_cnt_next = '0;
                    started_next = 1'b0;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!started_reg && top_zero && !last_slot)
                begin
                    // Leading all-zero group: drop it.
                    bcd_next     = bcd_reg << GROUP_BITS;
                    grp_cnt_next = grp_cnt_reg + GRP_CNT_W'(1);
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_group_next = b2d_pkg::DIGIT_GROUP_W'(top_group);
                    out_count_next = started_reg ?
                                     b2d_pkg::GROUP_COUNT_W'(GROUP_DIGITS) :
                                     lead_count;
                    out_last_next  = last_slot;
                    started_next   = 1'b1;
                    bcd_next       = bcd_reg << GROUP_BITS;
                    grp_cnt_next   = grp_cnt_reg + GRP_CNT_W'(1);
                    if (last_slot)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bit_cnt_reg   <= '0;
            grp_cnt_reg   <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            grp_cnt_reg   <= grp_cnt_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        bin_reg       <= bin_next;
        bcd_reg       <= bcd_next;
        out_group_reg <= out_group_next;
        out_count_reg <= out_count_next;
        out_last_reg  <= out_last_next;
    end

    assign in_ch.ready         = (state_reg == ST_IDLE);
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.digit_group  = out_group_reg;
    assign out_ch.group_digits = out_count_reg;
    assign out_ch.last_group   = out_last_reg;

endmodule

>>> tb/sv/tb_binary256_to_decimal_unit.sv
`timescale 1ns / 1ps

module tb_binary256_to_decimal_unit;

    localparam int WORD_W           = b2d_pkg::WORD_W;
    localparam int DIGIT_GROUP_W    = b2d_pkg::DIGIT_GROUP_W;
    localparam int GROUP_COUNT_W    = b2d_pkg::GROUP_COUNT_W;
    localparam int BCD_W            = b2d_pkg::BCD_W;
    localparam int VALUE_BITS       = b2d_pkg::VALUE_BITS_DEF;
    localparam int GROUP_DIGITS     = b2d_pkg::GROUP_DIGITS_DEF;
    localparam int MAX_DIGITS       = 78;
    localparam int NUM_PHASES       = 4;
    localparam int RANDOM_PER_PHASE = 108;
    localparam int SETTLE_CYCLES    = 300;
    localparam int STALL_LIMIT      = 4000;
    localparam int REPORT_LIMIT     = 10;

    typedef logic [4*WORD_W-1:0] value_t;

    typedef struct packed {
        logic [DIGIT_GROUP_W-1:0] digit_group;
        logic [GROUP_COUNT_W-1:0] group_digits;
        logic                     last_group;
    } bcd_group_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    b2d_in_if  in_ch ();
    b2d_out_if out_ch ();

    // Variables behind the block's inputs, known from time zero.
    logic   send_valid = 1'b0;
    value_t send_value = '0;
    logic   take_ready = 1'b0;

    assign in_ch.valid         = send_valid;
    assign in_ch.value_lo      = send_value[WORD_W-1:0];
    assign in_ch.value_mid     = send_value[2*WORD_W-1:WORD_W];
    assign in_ch.value_hi_low  = send_value[3*WORD_W-1:2*WORD_W];
    assign in_ch.value_hi_high = send_value[4*WORD_W-1:3*WORD_W];
    assign out_ch.ready        = take_ready;

    value_t     values_to_convert[$];
    bcd_group_t expected_groups[$];
    bcd_group_t seen_group;
    bcd_group_t oldest_group;
    int         send_idle_pct  = 0;
    int         take_stall_pct = 0;
    int         mismatches     = 0;
    int         quiet_cycles   = 0;

    binary256_to_decimal_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #10 clk = ~clk;

    // Ten to the power k at the full value width.
    function automatic value_t ten_power(input int k);
        value_t p;
        p = value_t'(1);
        repeat (k)
            p = p * value_t'(10);
        return p;
    endfunction

    // Splits a value into decimal digits and queues the BCD groups it should give,
    // most significant group first, the leading group right-aligned.
    function automatic void predict_decimal_groups(input value_t value);
        logic [BCD_W-1:0] digits [MAX_DIGITS+1];
        value_t           rest;
        value_t           remainder;
        value_t           keep_mask;
        bcd_group_t       grp;
        int               n;
        int               ngroups;
        int               pos;
        int               cnt;
        keep_mask = (VALUE_BITS >= 4*WORD_W) ? '1 : ((value_t'(1) << VALUE_BITS) - 1);
        rest = value & keep_mask;
        n = 0;
        if (rest == '0)
        begin
            digits[0] = '0;
            n = 1;
        end
        while (rest != '0 && n <= MAX_DIGITS)
        begin
            remainder = rest % value_t'(10);
            digits[n] = remainder[BCD_W-1:0];
            rest = rest / value_t'(10);
            n++;
        end
        ngroups = (n + GROUP_DIGITS - 1) / GROUP_DIGITS;
        pos = n;
        for (int g = 0; g < ngroups; g++)
        begin
            cnt = (g == 0) ? n - GROUP_DIGITS * (ngroups - 1) : GROUP_DIGITS;
            grp.digit_group = '0;
            for (int k = 0; k < cnt; k++)
            begin
                pos--;
                grp.digit_group = (grp.digit_group << BCD_W) | DIGIT_GROUP_W'(digits[pos]);
            end
            grp.group_digits = GROUP_COUNT_W'(cnt);
            grp.last_group   = (g + 1 == ngroups);
            expected_groups.push_back(grp);
        end
    endfunction

    // Random operands: full width, random bit length, near a power of ten, or
    // built digit by digit, rich in zeros and nines.
    function automatic value_t random_value();
        value_t raw;
        value_t v;
        int     len;
        int     d;
        raw = {$urandom(), $urandom(), $urandom(), $urandom(),
               $urandom(), $urandom(), $urandom(), $urandom()};
        case ($urandom_range(3, 0))
            0: v = raw;
            1:
            begin
                len = $urandom_range(4*WORD_W, 1);
                v = raw >> (4*WORD_W - len);
            end
            2: v = ten_power($urandom_range(MAX_DIGITS - 1, 0))
                   + value_t'($urandom_range(4, 0)) - value_t'(2);
            default:
            begin
                v = '0;
                len = $urandom_range(MAX_DIGITS - 1, 1);
                repeat (len)
                begin
                    case ($urandom_range(2, 0))
                        0:       d = 0;
                        1:       d = 9;
                        default: d = $urandom_range(9, 0);
                    endcase
                    v = v * value_t'(10) + value_t'(d);
                end
            end
        endcase
        return v;
    endfunction

    // Sender: presents queued values, predicting each one as its beat is taken.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            send_valid <= 1'b0;
        end
        else
        begin
            if (send_valid && in_ch.ready)
                predict_decimal_groups(send_value);
            if (!send_valid || in_ch.ready)
            begin
                if (values_to_convert.size() != 0 && $urandom_range(99, 0) >= send_idle_pct)
                begin
                    send_valid <= 1'b1;
                    send_value <= values_to_convert.pop_front();
                end
                else
                begin
                    send_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, and each taken beat is checked against the oldest
    // expected group.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            take_ready <= 1'b0;
        end
        else
        begin
            take_ready <= ($urandom_range(99, 0) >= take_stall_pct);
            if (out_ch.valid && take_ready)
            begin
                seen_group = {out_ch.digit_group, out_ch.group_digits, out_ch.last_group};
                if (expected_groups.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: unexpected group %h digits %0d last %0b", $realtime,
                                 seen_group.digit_group, seen_group.group_digits,
                                 seen_group.last_group);
                end
                else
                begin
                    oldest_group = expected_groups.pop_front();
                    if (seen_group.digit_group  !== oldest_group.digit_group  ||
                        seen_group.group_digits !== oldest_group.group_digits ||
                        seen_group.last_group   !== oldest_group.last_group)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("%0t: group mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                                     $realtime, oldest_group.digit_group,
                                     oldest_group.group_digits, oldest_group.last_group,
                                     seen_group.digit_group, seen_group.group_digits,
                                     seen_group.last_group);
                    end
                end
            end
        end
    end

    // Watchdog on cycles where neither channel moves a beat.
    always @(posedge clk)
    begin
        if (!rst_n || (send_valid && in_ch.ready) || (out_ch.valid && take_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus: directed corner values, then random values over four phases of sender idling and receiver stalls.
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Zero, small values and each side of every group boundary.
        values_to_convert.push_back('0);
        values_to_convert.push_back(value_t'(1));
        values_to_convert.push_back(value_t'(9));
        values_to_convert.push_back(value_t'(10));
        for (int k = GROUP_DIGITS; k < MAX_DIGITS; k += GROUP_DIGITS)
        begin
            values_to_convert.push_back(ten_power(k) - value_t'(1));
            values_to_convert.push_back(ten_power(k));
        end
        values_to_convert.push_back(ten_power(MAX_DIGITS - 1) - value_t'(1));
        values_to_convert.push_back(ten_power(MAX_DIGITS - 1));
        // A full middle group of zeros.
        values_to_convert.push_back(ten_power(2 * GROUP_DIGITS) + value_t'(1));
        // Word-level extremes and alternating bit patterns.
        values_to_convert.push_back({4*WORD_W{1'b1}});
        values_to_convert.push_back({{3*WORD_W{1'b0}}, {WORD_W{1'b1}}});
        values_to_convert.push_back({{WORD_W{1'b1}}, {3*WORD_W{1'b0}}});
        values_to_convert.push_back({WORD_W{4'hA}});
        values_to_convert.push_back({WORD_W{4'h5}});

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    take_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 82;
                    take_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    take_stall_pct = 82;
                end
                default:
                begin
                    send_idle_pct  = 35;
                    take_stall_pct = 35;
                end
            endcase
            repeat (RANDOM_PER_PHASE)
                values_to_convert.push_back(random_value());
            // Let the sender run dry, then hold it back until every group is in.
            @(negedge clk);
            while (values_to_convert.size() != 0 || send_valid)
                @(negedge clk);
            while (expected_groups.size() != 0)
                @(negedge clk);
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_groups.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> binary256_to_decimal_unit.f
hdl/b2d_pkg.sv
hdl/b2d_if.sv
hdl/binary256_to_decimal_unit.sv
tb/sv/tb_binary256_to_decimal_unit.sv
